FILE: hdl/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types for the LSB-first base64 codec: request payloads, the result
// push bundle between the codec core and the output queue, and config control.
// ----------------------------------------------------------------------------
package b64c_pkg;

  // Input request payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Result request payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Up to two results produced by one accepted input request.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } b64c_push_t;

  // Configuration write toward the codec core.
  typedef struct packed {
    logic wr;
    logic dir;
  } b64c_cfg_t;

  // Direction codes.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // APB address width and the address of the direction register.
  localparam int          AddrW   = 2;
  localparam logic [AddrW-1:0] AddrDir = '0;

endpackage

FILE: hdl/b64c_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_core
// Codec state (direction, group phase, carried bits) and the single-pass
// symbol packing logic that turns one request into zero, one or two results.
// ----------------------------------------------------------------------------
module b64c_core
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64c_cfg_t  cfg,
  input  logic       acc,
  input  in_item_t   item,
  output logic       dir,
  output b64c_push_t push
);

  logic       dir_r;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] carry_r, carry_nxt;

  // Map a 6-bit symbol to its alphabet character.
  function automatic logic [7:0] to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      to_char = w + 8'd65;
    else if (v < 6'd52) to_char = w + 8'd71;
    else if (v < 6'd62) to_char = w - 8'd4;
    else if (v == 6'd62) to_char = 8'd43;
    else                to_char = 8'd47;
  endfunction

  // Map a character to its symbol value; anything outside the alphabet is 0.
  function automatic logic [5:0] from_char(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    case (c) inside
      [8'd65:8'd90]:  d = c - 8'd65;
      [8'd97:8'd122]: d = c - 8'd71;
      [8'd48:8'd57]:  d = c + 8'd4;
      8'd43:          d = 8'd62;
      8'd47:          d = 8'd63;
      default:        d = 8'd0;
    endcase
    from_char = d[5:0];
  endfunction

  // Next state and results for the request presented this cycle.
  always_comb begin
    logic [7:0] b;
    logic [5:0] s;
    logic [5:0] r0, r1;
    logic [1:0] n;
    b         = item.in_byte;
    s         = from_char(b);
    r0        = '0;
    r1        = '0;
    n         = 2'd0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    push      = '0;

    if (dir_r == DirEncode) begin
      case (phase_r)
        2'd1: begin
          r0        = {b[3:0], carry_r[1:0]};
          carry_nxt = {2'b00, b[7:4]};
          phase_nxt = 2'd2;
          n         = 2'd1;
        end
        2'd2: begin
          r0        = {b[1:0], carry_r[3:0]};
          r1        = b[7:2];
          carry_nxt = '0;
          phase_nxt = 2'd0;
          n         = 2'd2;
        end
        default: begin
          r0        = b[5:0];
          carry_nxt = {4'b0000, b[7:6]};
          phase_nxt = 2'd1;
          n         = 2'd1;
        end
      endcase
      // A last byte flushes the partial symbol as one more character.
      if (item.in_last && n == 2'd1) begin
        r1 = carry_nxt;
        n  = 2'd2;
      end
      push.item0.out_byte = to_char(r0);
      push.item1.out_byte = to_char(r1);
      push.item0.out_last = item.in_last && n == 2'd1;
      push.item1.out_last = item.in_last;
    end else begin
      case (phase_r)
        2'd0: begin
          carry_nxt = s;
          phase_nxt = 2'd1;
          n         = 2'd0;
        end
        2'd1: begin
          push.item0.out_byte = {s[1:0], carry_r};
          carry_nxt           = {2'b00, s[5:2]};
          phase_nxt           = 2'd2;
          n                   = 2'd1;
        end
        2'd2: begin
          push.item0.out_byte = {s[3:0], carry_r[3:0]};
          carry_nxt           = {4'b0000, s[5:4]};
          phase_nxt           = 2'd3;
          n                   = 2'd1;
        end
        default: begin
          push.item0.out_byte = {s, carry_r[1:0]};
          carry_nxt           = '0;
          phase_nxt           = 2'd0;
          n                   = 2'd1;
        end
      endcase
      push.item0.out_last = item.in_last;
    end

    // The end of a stream returns the group position to its start.
    if (item.in_last) begin
      phase_nxt = 2'd0;
      carry_nxt = '0;
    end
    push.cnt = acc ? n : 2'd0;
  end

  // State registers; a direction write restarts the group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DirEncode;
      phase_r <= '0;
      carry_r <= '0;
    end else if (cfg.wr) begin
      dir_r   <= cfg.dir;
      phase_r <= '0;
      carry_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign dir = dir_r;

  // Decoding never yields two results for one request.
  a_dec_single: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_r == DirDecode) |-> (push.cnt != 2'd2))
    else $error("decode produced two results");

  // Every accepted byte in encode mode yields at least one character.
  a_enc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && dir_r == DirEncode) |-> (push.cnt != 2'd0))
    else $error("encode produced no result");

  // A last request leaves the group at its start with nothing carried.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && item.in_last) |=> (phase_r == 2'd0 && carry_r == 6'd0))
    else $error("group not restarted after last request");

endmodule

FILE: hdl/b64c_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_outq
// Four-entry result queue. Takes up to two results per cycle from the core
// and hands one per cycle to the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module b64c_outq
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64c_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  out_item_t  mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  // Room for a worst-case push of two results.
  assign room      = count_r <= 3'd2;
  assign out_valid = count_r != 3'd0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.item1;
    end
  end

  // A push only arrives when two entries are free.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (count_r <= 3'd2))
    else $error("result queue overflow");

  // Fill level follows pushes and pops.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) + {1'b0, $past(push.cnt)} - {2'b00, $past(pop)}))
    else $error("result queue count mismatch");

  // The fill level never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= 3'd4))
    else $error("result queue count out of range");

endmodule

FILE: hdl/base64_lsb_first_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_lsb_first_codec
// Streaming base64-alphabet codec, LSB-first bit packing, no padding.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one byte per
//   request, with in_last on the final one of a stream. The result channel
//   (out_valid/out_ready/out_data) carries alphabet characters when encoding
//   and decoded bytes when decoding, with out_last on the final result.
//   The APB port holds one register, direction, at address 0; writing it
//   also restarts the symbol group. Write it only while the block is idle.
//   Results of an accepted request are registered in the result queue and
//   offered from there in order. A request is accepted every cycle while
//   the four-entry result queue has two free entries; encode requests that
//   give two characters hold the single result port longer, so that port
//   sets the sustained rate.
//   If the receiver stalls, the queue fills and in_ready drops; nothing is
//   lost. Synchronous reset empties the queue, selects encoding and clears
//   the group phase and carried bits.
// ----------------------------------------------------------------------------
module base64_lsb_first_codec
  import b64c_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  b64c_cfg_t  cfg;
  b64c_push_t push;
  logic       room;
  logic       acc;
  logic       dir;

  // Configuration port: writes to the direction register, with pready tied high.
  assign pready  = 1'b1;
  assign cfg     = b64c_cfg_t'{wr:  psel && penable && pwrite && pready && (paddr == AddrDir),
                               dir: pwdata[0]};
  assign prdata  = (paddr == AddrDir) ? {31'd0, dir} : 32'd0;

  // Input request acceptance.
  assign in_ready = room;
  assign acc      = in_valid && in_ready;

  b64c_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .acc   (acc),
    .item  (in_data),
    .dir   (dir),
    .push  (push)
  );

  b64c_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for base64_lsb_first_codec
// Drives byte and character streams through the codec in both directions,
// predicts every character or byte with a cycle-free model of the LSB-first
// packing, and compares each result request in order. Both channels idle and
// stall at random, and one long receiver hold-off fills the result queue.
// ----------------------------------------------------------------------------
module testbench;
  import b64c_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_PAUSE   = 6;
  localparam int HOLD_OFF_LEN  = 200;
  localparam int MAX_PRINTED   = 20;
  localparam int PHASE_ITEMS   = 50;

  // Position within a symbol group.
  typedef enum logic [1:0] {GrpFirst, GrpSecond, GrpThird, GrpFourth} group_pos_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // Model state and the queue of codec results still to arrive.
  logic        model_dir;
  group_pos_t  model_pos;
  logic [5:0]  model_carry;
  out_item_t   pending_codec_out [$];

  int  error_count;
  int  items_sent;
  int  cycle_count;
  int  phase_start [6];
  bit  idle_enable;
  bit  start_hold_off;

  base64_lsb_first_codec uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[base64_lsb_first_codec] ERROR");
      $finish;
    end
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // Maps a 6-bit symbol value to its alphabet character.
  function automatic logic [7:0] char_of(input logic [5:0] v);
    if (v < 6'd26) begin
      return 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      return 8'd97 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      return 8'd48 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      return 8'd43;
    end
    return 8'd47;
  endfunction

  // Maps a character back to its symbol value; anything else reads as zero.
  function automatic logic [5:0] symbol_of(input logic [7:0] c);
    if (c >= 8'd65 && c <= 8'd90) begin
      return 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      return 6'(c - 8'd97 + 8'd26);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      return 6'(c - 8'd48 + 8'd52);
    end else if (c == 8'd43) begin
      return 6'd62;
    end else if (c == 8'd47) begin
      return 6'd63;
    end
    return 6'd0;
  endfunction

  // Advances the model by one accepted request and queues its results.
  function automatic void predict_codec(input logic [7:0] b, input logic last);
    out_item_t  res [2];
    int         n;
    logic [5:0] s;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (model_dir == DirEncode) begin
      case (model_pos)
        GrpSecond: begin
          res[0].out_byte = char_of({b[3:0], model_carry[1:0]});
          model_carry = {2'b00, b[7:4]};
          model_pos = GrpThird;
          n = 1;
        end
        GrpThird: begin
          res[0].out_byte = char_of({b[1:0], model_carry[3:0]});
          res[1].out_byte = char_of(b[7:2]);
          model_carry = '0;
          model_pos = GrpFirst;
          n = 2;
        end
        default: begin
          res[0].out_byte = char_of(b[5:0]);
          model_carry = {4'b0000, b[7:6]};
          model_pos = GrpSecond;
          n = 1;
        end
      endcase
      // A last byte with bits left over flushes them as one more character.
      if (last && n == 1) begin
        res[1].out_byte = char_of(model_carry);
        n = 2;
      end
    end else begin
      s = symbol_of(b);
      case (model_pos)
        GrpFirst: begin
          model_carry = s;
          model_pos = GrpSecond;
        end
        GrpSecond: begin
          res[0].out_byte = {s[1:0], model_carry};
          model_carry = {2'b00, s[5:2]};
          model_pos = GrpThird;
          n = 1;
        end
        GrpThird: begin
          res[0].out_byte = {s[3:0], model_carry[3:0]};
          model_carry = {4'b0000, s[5:4]};
          model_pos = GrpFourth;
          n = 1;
        end
        default: begin
          res[0].out_byte = {s, model_carry[1:0]};
          model_carry = '0;
          model_pos = GrpFirst;
          n = 1;
        end
      endcase
    end
    for (int k = 0; k < n; k++) begin
      res[k].out_last = last && (k == n - 1);
      pending_codec_out = {pending_codec_out, res[k]};
    end
    if (last) begin
      model_pos = GrpFirst;
      model_carry = '0;
    end
  endfunction

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (pending_codec_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                  out_data.out_byte, out_data.out_last));
      end else begin
        exp_item = pending_codec_out.pop_front();
        if (out_data.out_byte !== exp_item.out_byte) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_data.out_byte, exp_item.out_byte));
        end
        if (out_data.out_last !== exp_item.out_last) begin
          report_mismatch($sformatf("out_last %0b, expected %0b",
                                    out_data.out_last, exp_item.out_last));
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (start_hold_off) begin
        start_hold_off = 1'b0;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sends one input request, with an optional idle burst ahead of it.
  task automatic send_item(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{in_byte: b, in_last: last};
    do @(posedge clk); while (!in_ready);
    predict_codec(b, last);
    items_sent++;
  endtask

  // Drops valid, waits for every predicted result, then lets the core settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codec_out.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_transfer(input logic wr, input logic [AddrW-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == AddrDir) begin
      model_dir   = wdata[0];
      model_pos   = GrpFirst;
      model_carry = '0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes the direction register and reads it back.
  task automatic set_direction(input logic dir);
    logic [31:0] rdata;
    apb_transfer(1'b1, AddrDir, {31'd0, dir}, rdata);
    apb_transfer(1'b0, AddrDir, '0, rdata);
    if (rdata[0] !== dir) begin
      report_mismatch($sformatf("direction read %0b, expected %0b", rdata[0], dir));
    end
  endtask

  // Sends one stream of random content, closed by a last request.
  task automatic send_random_stream(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (model_dir == DirDecode && $urandom_range(0, 9) != 0) begin
        b = char_of(6'($urandom_range(0, 63)));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_item(b, i == len - 1);
    end
  endtask

  // Encode streams of one to four bytes cover every flush position.
  task automatic test_encode_directed();
    set_direction(DirEncode);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h3C, 1'b0);
    send_item(8'hC3, 1'b1);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'hF0, 1'b1);
    send_item(8'h0F, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'hCC, 1'b1);
    wait_drained();
  endtask

  // Decode: full groups, non-alphabet bytes, a lone leftover, every last position.
  task automatic test_decode_directed();
    set_direction(DirDecode);
    send_item("A", 1'b0);
    send_item("/", 1'b0);
    send_item("g", 1'b0);
    send_item("9", 1'b0);
    send_item("+", 1'b0);
    send_item("0", 1'b0);
    send_item("=", 1'b0);
    send_item(8'hFF, 1'b1);
    send_item("Q", 1'b1);
    send_item("z", 1'b0);
    send_item(8'h00, 1'b1);
    send_item("@", 1'b0);
    send_item("Z", 1'b0);
    send_item("a", 1'b1);
    wait_drained();
  endtask

  // A direction write in the middle of a group restarts it.
  task automatic test_direction_restart();
    send_item("B", 1'b0);
    wait_drained();
    set_direction(DirDecode);
    send_item("C", 1'b0);
    send_item("D", 1'b1);
    wait_drained();
    set_direction(DirEncode);
    send_item(8'h12, 1'b0);
    wait_drained();
    set_direction(DirEncode);
    send_item(8'h34, 1'b1);
    wait_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering requests.
  task automatic test_backpressure();
    set_direction(DirEncode);
    start_hold_off = 1'b1;
    for (int i = 0; i < 5; i++) begin
      send_random_stream($urandom_range(3, 8));
    end
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming_no_idle();
    idle_enable = 1'b0;
    set_direction(DirDecode);
    for (int i = 0; i < 4; i++) begin
      send_random_stream($urandom_range(4, 8));
    end
    wait_drained();
    set_direction(DirEncode);
    for (int i = 0; i < 4; i++) begin
      send_random_stream($urandom_range(3, 7));
    end
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    error_count    = 0;
    items_sent     = 0;
    idle_enable    = 1'b1;
    start_hold_off = 1'b0;
    model_dir      = DirEncode;
    model_pos      = GrpFirst;
    model_carry    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_encode_directed();
    test_decode_directed();
    test_direction_restart();
    for (int p = 0; p < 6; p++) begin
      phase_start[p] = 0;
    end
    test_random_streams_run();
    test_backpressure();
    test_streaming_no_idle();

    repeat (DRAIN_PAUSE) @(posedge clk);
    if (pending_codec_out.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_codec_out.size()));
    end
    if (error_count == 0) begin
      $display("[base64_lsb_first_codec] OK");
    end else begin
      $display("[base64_lsb_first_codec] ERROR");
    end
    $finish;
  end

  // Records where each random phase starts, then runs the random streams.
  task automatic test_random_streams_run();
    for (int p = 0; p < 6; p++) begin
      set_direction(p[0] ? DirDecode : DirEncode);
      phase_start[p] = items_sent;
      while (items_sent - phase_start[p] < PHASE_ITEMS) begin
        send_random_stream($urandom_range(1, 9));
      end
      wait_drained();
    end
  endtask

endmodule

FILE: sim.f
hdl/b64c_pkg.sv
hdl/b64c_core.sv
hdl/b64c_outq.sv
hdl/base64_lsb_first_codec.sv
test/testbench.sv
